// File: hdl/iplu_pkg.sv
// Package: transaction types, event and mode codes for the IPL upload handshake.
`timescale 1ns / 1ps
`default_nettype none

package iplu_pkg;

	// Event codes
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_INIT    = 3'd1;
	localparam logic [2:0] EV_DATA    = 3'd2;
	localparam logic [2:0] EV_NEW     = 3'd3;
	localparam logic [2:0] EV_END     = 3'd4;
	localparam logic [2:0] EV_INVALID = 3'd5;

	// Mode codes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_XFER = 2'd1;
	localparam logic [1:0] MODE_EXEC = 2'd2;

	// Handshake constants
	localparam logic [7:0] COOKIE_INIT = 8'hCC;
	localparam logic [7:0] COOKIE_ZERO = 8'h00;
	localparam logic [7:0] BLOCK_STEP  = 8'd4;
	localparam logic [7:0] ECHO_RESET  = 8'hAA;
	localparam logic [7:0] PORT1_RESET = 8'hBB;

	// Host mailbox snapshot
	typedef struct packed {
		logic [7:0] cookie_in;
		logic [7:0] payload_in;
		logic [7:0] addr_low_in;
		logic [7:0] addr_high_in;
	} iplu_snap_t;

	// Result of one snapshot
	typedef struct packed {
		logic [2:0]  event_code;
		logic        mem_write_en;
		logic [15:0] mem_write_addr;
		logic [7:0]  mem_write_data;
		logic        echo_valid;
		logic [7:0]  echo_value;
		logic [1:0]  mode_out;
		logic [15:0] entry_addr;
	} iplu_res_t;

	// Handshake state
	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  last_cookie;
		logic [15:0] write_pointer;
		logic [7:0]  port0_echo;
	} iplu_state_t;

endpackage

`default_nettype wire

// File: hdl/iplu_classify.sv
// Cookie classifier: next handshake state and result for one mailbox snapshot.
`timescale 1ns / 1ps
`default_nettype none

module iplu_classify (
	input  wire iplu_pkg::iplu_snap_t  snap,
	input  wire iplu_pkg::iplu_state_t cur,
	output iplu_pkg::iplu_state_t      nxt,
	output iplu_pkg::iplu_res_t        res
);
	import iplu_pkg::*;

	logic        active;
	logic [7:0]  plus4_raw;
	logic [7:0]  plus4;
	logic [8:0]  last_p1;
	logic [15:0] addr;
	logic [2:0]  ev;

	assign addr      = {snap.addr_high_in, snap.addr_low_in};
	assign active    = (cur.mode != MODE_EXEC) && (snap.cookie_in != cur.last_cookie);
	assign plus4_raw = cur.last_cookie + BLOCK_STEP;
	assign plus4     = (plus4_raw == 8'd0) ? BLOCK_STEP : plus4_raw;
	// no wrap here: a last cookie of 0xFF never matches plus one
	assign last_p1   = {1'b0, cur.last_cookie} + 9'd1;

	// Classify the cookie
	always_comb begin
		if (!active) begin
			ev = EV_NONE;
		end else if (snap.cookie_in == COOKIE_INIT && cur.mode != MODE_XFER) begin
			ev = EV_INIT;
		end else if (snap.cookie_in == COOKIE_ZERO || {1'b0, snap.cookie_in} == last_p1) begin
			ev = EV_DATA;
		end else if (snap.cookie_in == plus4) begin
			ev = (snap.payload_in != 8'd0) ? EV_NEW : EV_END;
		end else begin
			ev = EV_INVALID;
		end
	end

	// State update and result fields
	always_comb begin
		nxt = cur;
		res = '0;
		res.event_code = ev;
		if (ev != EV_NONE && ev != EV_INVALID) begin
			nxt.last_cookie = snap.cookie_in;
		end
		case (ev)
			EV_INIT: begin
				nxt.mode          = MODE_XFER;
				nxt.write_pointer = addr;
			end
			EV_DATA: begin
				res.mem_write_en   = 1'b1;
				res.mem_write_addr = cur.write_pointer;
				res.mem_write_data = snap.payload_in;
				nxt.write_pointer  = cur.write_pointer + 16'd1;
			end
			EV_NEW: begin
				nxt.write_pointer = addr;
			end
			EV_END: begin
				nxt.mode       = MODE_EXEC;
				res.entry_addr = addr;
			end
			default: begin
			end
		endcase
		// echo only once transferring; end event never echoes
		if ((ev == EV_INIT || ev == EV_DATA || ev == EV_NEW) && nxt.mode == MODE_XFER) begin
			nxt.port0_echo = snap.cookie_in;
			res.echo_valid = 1'b1;
		end
		res.echo_value = nxt.port0_echo;
		res.mode_out   = (nxt.mode == MODE_XFER || nxt.mode == MODE_EXEC) ? nxt.mode : MODE_IDLE;
	end

endmodule

`default_nettype wire

// File: hdl/ipl_upload_handshake.sv
// Top level: IPL upload handshake with input register, classifier and result register.
//
//  channel | direction | handshake           | payload
//  snap    | in        | snap_valid/snap_stall | iplu_snap_t (four mailbox bytes)
//  res     | out       | res_valid/res_stall   | iplu_res_t (event, RAM write, echo, mode)
//
// One snapshot per cycle while the result is not stalled; an accepted snapshot goes into the
// input register and then moves on to the result register, from which the result is taken.
// The state updates as a snapshot moves from the input register to the result register.
// Reset puts the block in not-initialised mode, echo 0xAA, last cookie and pointer zero.
// A stalled result holds; the input register still takes a transaction while it is
// empty or its own transaction moves on to the result register.
`timescale 1ns / 1ps
`default_nettype none

module ipl_upload_handshake (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  snap_valid,
	output logic                 snap_stall,
	input  wire iplu_pkg::iplu_snap_t snap,
	output logic                 res_valid,
	input  wire                  res_stall,
	output iplu_pkg::iplu_res_t  res
);
	import iplu_pkg::*;

	logic        valid_s1;
	iplu_snap_t  snap_s1;
	logic        valid_s2;
	iplu_res_t   res_s2;
	iplu_state_t state_q;
	iplu_state_t state_nxt;
	iplu_res_t   res_nxt;
	logic        adv;

	// Move stage 1 into the result register when it is free or being taken
	assign adv        = valid_s1 && (!valid_s2 || !res_stall);
	assign snap_stall = valid_s1 && !adv;

	iplu_classify u_classify (
		.snap (snap_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!snap_stall) begin
			valid_s1 <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && !snap_stall) begin
			snap_s1 <= snap;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	// Handshake state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= MODE_IDLE;
			state_q.last_cookie   <= COOKIE_ZERO;
			state_q.write_pointer <= 16'd0;
			state_q.port0_echo    <= ECHO_RESET;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	// Execute mode is final
	a_exec_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_EXEC |=> state_q.mode == MODE_EXEC)
		else $error("execute mode left");

	// A transaction leaving stage 1 shows up as a result
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced transaction lost");

	// Shown echo value matches the held echo state
	a_echo_state: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.echo_value == state_q.port0_echo)
		else $error("echo value out of step with state");

	// RAM writes come only from data events
	a_write_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.mem_write_en |-> res_s2.event_code == EV_DATA)
		else $error("RAM write without data event");

	// Stage 1 never overwritten while it waits
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(snap_s1))
		else $error("stage 1 lost a waiting transaction");

endmodule

`default_nettype wire
